// File: hw/rtl/bncs_pkg.sv
// Shared types, codes and saturation helper for the batch normalisation block.
`default_nettype none
package bncs_pkg;

   // Operation codes
   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_CLOSE = 2'd1;
   localparam logic [1:0] OP_NORM  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   // Table write targets
   localparam logic [1:0] TS_GAMMA = 2'd0;
   localparam logic [1:0] TS_BETA  = 2'd1;
   localparam logic [1:0] TS_RMEAN = 2'd2;
   localparam logic [1:0] TS_RVAR  = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_TRAINING = 2'd0;
   localparam logic [1:0] CSR_EPSILON  = 2'd1;
   localparam logic [1:0] CSR_MOMENTUM = 2'd2;
   localparam logic [1:0] CSR_ELEMENTS = 2'd3;

   // One channel's state as held in the state memory
   typedef struct packed {
      logic [51:0] sum;
      logic [63:0] sq;
      logic [31:0] bmean;
      logic [31:0] bvar;
      logic [31:0] rmean;
      logic [31:0] rvar;
      logic [31:0] gamma;
      logic [31:0] beta;
   } entry_type;

   // Clip to signed 32 bits; bit 32 of the result flags clipping
   function automatic logic [32:0] sat32(input logic signed [66:0] v);
      logic [32:0] r;
      if (v > 67'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -67'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/batch_norm_channel_stream.sv
// Per-channel batch normalisation engine with a state memory and shared arithmetic units.
`default_nettype none
// Works on one transaction at a time. Each channel's sums, batch and running
// statistics, gamma and beta sit in one entry of a synchronous state memory,
// which is read on acceptance and written back when an accumulate, close or
// table write finishes (a normalise writes nothing back). An accumulate reads,
// adds and writes back; a table write reads, modifies and writes back. A close
// runs two passes of the bit-serial divider plus, in training mode, the blend
// multiplies. A normalise runs 32 square-root steps, 64 divider steps and the
// gamma multiply. req_ready is high whenever the engine is between transactions,
// also while a result still waits on rsp_ready. Channels at or above CHANNELS
// are dropped. Unwritten memory entries read as their reset values via
// per-channel valid bits, so no clearing pass follows reset.
module batch_norm_channel_stream #(
   parameter int CHANNELS      = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_operation,
   input  wire  [3:0]  req_channel,
   input  wire  [31:0] req_sample_value,
   input  wire  [1:0]  req_table_select,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [3:0]  rsp_out_channel,
   output logic [31:0] rsp_normalized_value,
   output logic        rsp_saturated,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_wdata
);
   import bncs_pkg::*;

   localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [31:0] ONE = 32'(64'd1 << FRACTION_BITS);
   localparam entry_type ENT_RESET = '{sum: '0, sq: '0, bmean: '0, bvar: ONE,
                                        rmean: '0, rvar: ONE, gamma: ONE, beta: '0};

   // Sequencer codes
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RD   = 5'd1;
   localparam logic [4:0] S_ACC  = 5'd2;
   localparam logic [4:0] S_DIV  = 5'd3;
   localparam logic [4:0] S_MEAN = 5'd4;
   localparam logic [4:0] S_MS   = 5'd5;
   localparam logic [4:0] S_VAR  = 5'd6;
   localparam logic [4:0] S_BL1  = 5'd7;
   localparam logic [4:0] S_BL2  = 5'd8;
   localparam logic [4:0] S_BL3  = 5'd9;
   localparam logic [4:0] S_BL4  = 5'd10;
   localparam logic [4:0] S_WR   = 5'd11;
   localparam logic [4:0] S_SQRT = 5'd12;
   localparam logic [4:0] S_NDIV = 5'd13;
   localparam logic [4:0] S_NQ   = 5'd14;
   localparam logic [4:0] S_NM   = 5'd15;
   localparam logic [4:0] S_NY   = 5'd16;
   localparam logic [4:0] S_OUT  = 5'd17;

   // Divider result destinations
   localparam logic [1:0] PH_MEAN = 2'd0;
   localparam logic [1:0] PH_MS   = 2'd1;
   localparam logic [1:0] PH_NORM = 2'd2;

   // Configuration
   logic        training_ff;
   logic [15:0] epsilon_ff;
   logic [16:0] momentum_ff;
   logic [20:0] elements_ff;

   // State memory
   entry_type mem [CHANNELS];
   entry_type rd_data_ff;
   logic [CHANNELS-1:0] valid_ff, valid_in;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [3:0]  ch_ff, ch_in;
   logic [31:0] x_ff, x_in;
   logic [1:0]  sel_ff, sel_in;
   entry_type   ent_ff, ent_in;
   logic        neg_ff, neg_in;
   logic [31:0] mean_ff, mean_in;
   logic [63:0] ms_ff, ms_in;
   logic [31:0] var_ff, var_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [63:0] dq_ff, dq_in;
   logic [31:0] dr_ff, dr_in;
   logic [31:0] dd_ff, dd_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] sv_ff, sv_in;
   logic [63:0] sr_ff, sr_in;
   logic [63:0] sb_ff, sb_in;
   logic [31:0] xn_ff, xn_in;
   logic        flag_ff, flag_in;
   logic [31:0] y_ff, y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_ch_ff, rsp_ch_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic        rsp_sat_ff, rsp_sat_in;

   logic signed [32:0] mul_a, mul_b;
   logic [ChW-1:0] ch_idx, req_idx;
   logic           req_in_range;
   entry_type      entry;
   logic [16:0]    mom_c, keep_k;
   logic [31:0]    n32;

   // Combinational helpers
   logic [51:0]        sum_mag;
   logic signed [33:0] nvar;
   logic [32:0]        d_trial;
   logic               d_ge;
   logic [63:0]        s_sum;
   logic [63:0]        sq_add;
   logic [64:0]        sq_tot;
   logic [63:0]        m2, vdiff;
   logic [64:0]        v65;
   logic [31:0]        var_c;
   logic signed [66:0] blend, qv, yv;
   logic [32:0]        sat_r;
   logic [31:0]        mu;
   logic signed [33:0] diff;
   logic [33:0]        dmag;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_normalized_value = rsp_val_ff;
   assign rsp_saturated = rsp_sat_ff;

   assign req_idx = ChW'(req_channel);
   assign ch_idx = ChW'(ch_ff);
   assign req_in_range = ({5'd0, req_channel} < 9'(CHANNELS));
   assign entry = valid_ff[ch_idx] ? rd_data_ff : ENT_RESET;
   assign mom_c = (momentum_ff > 17'd65536) ? 17'd65536 : momentum_ff;
   assign keep_k = 17'd65536 - mom_c;
   assign n32 = (elements_ff == 21'd0) ? 32'd1 : {11'd0, elements_ff};
   assign prod_in = mul_a * mul_b;

   // Sequencer and datapath next values
   always_comb begin
      state_in = state_ff;   op_in = op_ff;     ch_in = ch_ff;     x_in = x_ff;
      sel_in = sel_ff;       ent_in = ent_ff;   neg_in = neg_ff;   mean_in = mean_ff;
      ms_in = ms_ff;         var_in = var_ff;   acc_in = acc_ff;   dq_in = dq_ff;
      dr_in = dr_ff;         dd_in = dd_ff;     cnt_in = cnt_ff;   phase_in = phase_ff;
      sv_in = sv_ff;         sr_in = sr_ff;     sb_in = sb_ff;     xn_in = xn_ff;
      flag_in = flag_ff;     y_in = y_ff;       valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in = rsp_ch_ff; rsp_val_in = rsp_val_ff; rsp_sat_in = rsp_sat_ff;
      mul_a = '0;
      mul_b = '0;

      sum_mag = entry.sum[51] ? (52'd0 - entry.sum) : entry.sum;
      nvar = training_ff ? {{2{entry.bvar[31]}}, entry.bvar}
                         : {{2{entry.rvar[31]}}, entry.rvar} + {18'd0, epsilon_ff};
      if (nvar < 34'sd1) nvar = 34'sd1;
      d_trial = {dr_ff, dq_ff[63]};
      d_ge = (d_trial >= {1'b0, dd_ff});
      s_sum = sr_ff + sb_ff;
      sq_add = prod_ff[63:0] >> FRACTION_BITS;
      sq_tot = {1'b0, ent_ff.sq} + {1'b0, sq_add};
      m2 = prod_ff[63:0] >> FRACTION_BITS;
      vdiff = (ms_ff > m2) ? (ms_ff - m2) : 64'd0;
      v65 = {1'b0, vdiff} + {49'd0, epsilon_ff};
      var_c = (v65 > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : v65[31:0];
      blend = 67'(acc_ff) + 67'(prod_ff) + 67'sd32768;
      blend = blend >>> 16;
      qv = neg_ff ? -$signed({3'd0, dq_ff}) : $signed({3'd0, dq_ff});
      yv = 67'(prod_ff >>> FRACTION_BITS) + 67'($signed(ent_ff.beta));
      sat_r = '0;
      mu = training_ff ? ent_ff.bmean : ent_ff.rmean;
      diff = $signed({{2{x_ff[31]}}, x_ff}) - $signed({{2{mu[31]}}, mu});
      dmag = diff[33] ? (34'd0 - diff) : diff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               ch_in = req_channel;
               x_in = req_sample_value;
               sel_in = req_table_select;
               if (req_in_range) state_in = S_RD;
            end
         end
         S_RD: begin
            ent_in = entry;
            neg_in = entry.sum[51];
            // square of |x| for an accumulate
            mul_a = x_ff[31] ? (33'sd0 - $signed({x_ff[31], x_ff}))
                             : $signed({1'b0, x_ff});
            mul_b = mul_a;
            case (op_ff)
               OP_ACCUM: state_in = S_ACC;
               OP_CLOSE: begin
                  dq_in = {12'd0, sum_mag};
                  dr_in = '0;
                  dd_in = n32;
                  cnt_in = 6'd63;
                  phase_in = PH_MEAN;
                  state_in = S_DIV;
               end
               OP_NORM: begin
                  sv_in = {32'd0, nvar[31:0]} << FRACTION_BITS;
                  sr_in = '0;
                  sb_in = 64'h4000_0000_0000_0000;
                  cnt_in = 6'd31;
                  state_in = S_SQRT;
               end
               default: begin
                  case (sel_ff)
                     TS_GAMMA: ent_in.gamma = x_ff;
                     TS_BETA:  ent_in.beta = x_ff;
                     TS_RMEAN: ent_in.rmean = x_ff;
                     default:  ent_in.rvar = x_ff;
                  endcase
                  state_in = S_WR;
               end
            endcase
         end
         S_ACC: begin
            ent_in.sq = sq_tot[64] ? '1 : sq_tot[63:0];
            ent_in.sum = ent_ff.sum + {{20{x_ff[31]}}, x_ff};
            state_in = S_WR;
         end
         // restoring divider, one quotient bit a cycle
         S_DIV: begin
            dr_in = d_ge ? 32'(d_trial - {1'b0, dd_ff}) : d_trial[31:0];
            dq_in = {dq_ff[62:0], d_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               case (phase_ff)
                  PH_MEAN: state_in = S_MEAN;
                  PH_MS:   state_in = S_MS;
                  default: state_in = S_NQ;
               endcase
            end
         end
         S_MEAN: begin
            sat_r = sat32(qv);
            mean_in = sat_r[31:0];
            dq_in = ent_ff.sq;
            dr_in = '0;
            dd_in = n32;
            cnt_in = 6'd63;
            phase_in = PH_MS;
            state_in = S_DIV;
         end
         S_MS: begin
            ms_in = dq_ff;
            mul_a = $signed({mean_ff[31], mean_ff});
            mul_b = mul_a;
            state_in = S_VAR;
         end
         S_VAR: begin
            var_in = var_c;
            ent_in.bmean = mean_ff;
            ent_in.bvar = var_c;
            ent_in.sum = '0;
            ent_in.sq = '0;
            mul_a = $signed({16'd0, mom_c});
            mul_b = $signed({ent_ff.rmean[31], ent_ff.rmean});
            state_in = training_ff ? S_BL1 : S_WR;
         end
         S_BL1: begin
            acc_in = prod_ff;
            mul_a = $signed({16'd0, keep_k});
            mul_b = $signed({mean_ff[31], mean_ff});
            state_in = S_BL2;
         end
         S_BL2: begin
            sat_r = sat32(blend);
            ent_in.rmean = sat_r[31:0];
            mul_a = $signed({16'd0, mom_c});
            mul_b = $signed({ent_ff.rvar[31], ent_ff.rvar});
            state_in = S_BL3;
         end
         S_BL3: begin
            acc_in = prod_ff;
            mul_a = $signed({16'd0, keep_k});
            mul_b = $signed({1'b0, var_ff});
            state_in = S_BL4;
         end
         S_BL4: begin
            sat_r = sat32(blend);
            ent_in.rvar = sat_r[31:0];
            state_in = S_WR;
         end
         S_WR: begin
            valid_in[ch_idx] = 1'b1;
            state_in = S_IDLE;
         end
         // integer square root, two bits a step
         S_SQRT: begin
            if (sv_ff >= s_sum) begin
               sv_in = sv_ff - s_sum;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_NDIV;
         end
         S_NDIV: begin
            neg_in = diff[33];
            dq_in = {31'd0, dmag[32:0]} << FRACTION_BITS;
            dr_in = '0;
            dd_in = sr_ff[31:0];
            cnt_in = 6'd63;
            phase_in = PH_NORM;
            state_in = S_DIV;
         end
         S_NQ: begin
            sat_r = sat32(qv);
            xn_in = sat_r[31:0];
            flag_in = sat_r[32];
            state_in = S_NM;
         end
         S_NM: begin
            mul_a = $signed({xn_ff[31], xn_ff});
            mul_b = $signed({ent_ff.gamma[31], ent_ff.gamma});
            state_in = S_NY;
         end
         S_NY: begin
            sat_r = sat32(yv);
            y_in = sat_r[31:0];
            flag_in = flag_ff | sat_r[32];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in = ch_ff;
               rsp_val_in = y_ff;
               rsp_sat_in = flag_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State memory: read on acceptance, written back in the write-back state
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rd_data_ff <= mem[req_idx];
      end
      if (state_ff == S_WR) begin
         mem[ch_idx] <= ent_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         training_ff <= 1'b0;
         epsilon_ff <= 16'd1;
         momentum_ff <= 17'd58982;
         elements_ff <= 21'd1;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_TRAINING: training_ff <= csr_wdata[0];
               CSR_EPSILON:  epsilon_ff <= csr_wdata[15:0];
               CSR_MOMENTUM: momentum_ff <= csr_wdata[16:0];
               CSR_ELEMENTS: elements_ff <= csr_wdata[20:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;     ch_ff <= ch_in;       x_ff <= x_in;       sel_ff <= sel_in;
      ent_ff <= ent_in;   neg_ff <= neg_in;     mean_ff <= mean_in; ms_ff <= ms_in;
      var_ff <= var_in;   acc_ff <= acc_in;     prod_ff <= prod_in; dq_ff <= dq_in;
      dr_ff <= dr_in;     dd_ff <= dd_in;       cnt_ff <= cnt_in;   phase_ff <= phase_in;
      sv_ff <= sv_in;     sr_ff <= sr_in;       sb_ff <= sb_in;     xn_ff <= xn_in;
      flag_ff <= flag_in; y_ff <= y_in;
      rsp_ch_ff <= rsp_ch_in;
      rsp_val_ff <= rsp_val_in;
      rsp_sat_ff <= rsp_sat_in;
   end

`ifndef SYNTHESIS
   // an in-range transaction always goes on to the memory read
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_range) |=> (state_ff == S_RD))
      else $error("accepted transaction did not start a read");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dr_ff < dd_ff))
      else $error("divider remainder out of range");

   // square-root weight is a single bit while stepping
   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> $onehot(sb_ff))
      else $error("square root weight not one-hot");

   // a result only appears from the output step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside output step");
`endif

endmodule
`default_nettype wire
